// ----- rtl/lzwc_pkg.sv -----
// Shared constants and types of the LZW byte compressor.
`timescale 1ns / 1ps
package lzwc_pkg;

    localparam int CODE_BITS_DEF = 12;
    localparam int BYTE_BITS     = 8;
    localparam int FIRST_CODE    = 256;
    localparam int EPOCH_BITS    = 4;

    // Operations that the controller asks of the dictionary.
    typedef struct packed {
        logic lookup;
        logic probe_next;
        logic insert;
        logic new_epoch;
    } t_dict_req;

    // Dictionary status, valid in the cycle after a lookup or probe.
    typedef struct packed {
        logic busy;
        logic hit;
        logic vacant;
    } t_dict_stat;

endpackage

// ----- rtl/lzwc_if.sv -----
// Valid/ready channel interfaces for the byte input and the code output.
`timescale 1ns / 1ps
interface lzwc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_stream;

    modport source (output valid, output byte_value, output end_of_stream, input ready);
    modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface lzwc_code_if #(
    parameter int CODE_BITS = 12
);
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] code_word;
    logic                 final_code;

    modport source (output valid, output code_word, output final_code, input ready);
    modport sink   (input valid, input code_word, input final_code, output ready);
endinterface

// ----- rtl/lzw_byte_compressor.sv -----
// Top level of the LZW byte compressor: prefix control and sequencing.
// Usage
//   i_byte_ch carries one byte per transfer with end_of_stream marking the
//   last byte of a stream. o_code_ch carries the emitted codes; final_code
//   is set on the last code of each stream. Both are valid/ready channels.
//   Each byte passes a start state, then the hash table is probed slot by
//   slot until the pair is found or an empty slot is reached; the last
//   byte of a stream is followed by a flush. The first byte of a stream
//   needs no lookup. A new byte is taken only once the previous one is done.
//   The dictionary memory has a single read port, so slots are probed one
//   at a time. A miss pushes the prefix code into the result queue.
//   Results wait in a four-entry queue; a byte is taken while room for two
//   results remains, so a stalled receiver only holds off input once three
//   or more results are waiting.
//   After reset, and after every fifteenth stream, a clearing pass over all
//   2^(CODE_BITS+1) slots wipes the dictionary; no byte is taken meanwhile.
//   At the end of each stream the dictionary is emptied and the next byte
//   starts a fresh stream.
`timescale 1ns / 1ps
module lzw_byte_compressor #(
    parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzwc_byte_if.sink   i_byte_ch,
    lzwc_code_if.source o_code_ch
);
    import lzwc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    localparam logic [CODE_BITS:0] NF_FIRST = (CODE_BITS+1)'(FIRST_CODE);
    localparam logic [CODE_BITS:0] NF_LIMIT = (CODE_BITS+1)'(1 << CODE_BITS);

    logic [1:0]           r_state, n_state;
    logic [CODE_BITS-1:0] r_prefix, n_prefix;
    logic                 r_prefix_valid, n_prefix_valid;
    logic [CODE_BITS:0]   r_next_free, n_next_free;
    logic [BYTE_BITS-1:0] r_byte;
    logic                 r_last;

    t_dict_req            dict_req;
    t_dict_stat           dict_stat;
    logic [CODE_BITS-1:0] dict_code;

    logic                 push;
    logic [CODE_BITS-1:0] push_code;
    logic                 push_final;
    logic                 room2;
    logic                 accept;

    assign i_byte_ch.ready = (r_state == ST_IDLE) && !dict_stat.busy && room2;
    assign accept          = i_byte_ch.valid && i_byte_ch.ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte_ch.byte_value;
            r_last <= i_byte_ch.end_of_stream;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_prefix       = r_prefix;
        n_prefix_valid = r_prefix_valid;
        n_next_free    = r_next_free;
        dict_req       = '0;
        push           = 1'b0;
        push_code      = r_prefix;
        push_final     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (!r_prefix_valid) begin
                    n_prefix       = CODE_BITS'(r_byte);
                    n_prefix_valid = 1'b1;
                    n_state        = r_last ? ST_FINAL : ST_IDLE;
                end else begin
                    dict_req.lookup = 1'b1;
                    n_state         = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (dict_stat.hit) begin
                    n_prefix = dict_code;
                    n_state  = r_last ? ST_FINAL : ST_IDLE;
                end else if (dict_stat.vacant) begin
                    push = 1'b1;
                    if (r_next_free != NF_LIMIT) begin
                        dict_req.insert = 1'b1;
                        n_next_free     = r_next_free + (CODE_BITS+1)'(1);
                    end
                    n_prefix = CODE_BITS'(r_byte);
                    n_state  = r_last ? ST_FINAL : ST_IDLE;
                end else begin
                    // Slot taken by another pair: step to the next one.
                    dict_req.probe_next = 1'b1;
                end
            end
            ST_FINAL: begin
                push               = 1'b1;
                push_final         = 1'b1;
                dict_req.new_epoch = 1'b1;
                n_prefix           = '0;
                n_prefix_valid     = 1'b0;
                n_next_free        = NF_FIRST;
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_prefix       <= '0;
            r_prefix_valid <= 1'b0;
            r_next_free    <= NF_FIRST;
        end else begin
            r_state        <= n_state;
            r_prefix       <= n_prefix;
            r_prefix_valid <= n_prefix_valid;
            r_next_free    <= n_next_free;
        end
    end

    lzwc_dict #(
        .CODE_BITS (CODE_BITS)
    ) u_dict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (dict_req),
        .i_prefix (r_prefix),
        .i_byte   (r_byte),
        .i_code   (r_next_free[CODE_BITS-1:0]),
        .o_stat   (dict_stat),
        .o_code   (dict_code)
    );

    lzwc_ofifo #(
        .CODE_BITS (CODE_BITS)
    ) u_ofifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_code    (push_code),
        .i_final   (push_final),
        .o_room2   (room2),
        .o_code_ch (o_code_ch)
    );

    // An insert must land on an empty slot and never during the clearing pass.
    a_insert_vacant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dict_req.insert |-> (dict_stat.vacant && !dict_stat.busy))
        else $error("dictionary insert onto an occupied slot");

    a_next_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= NF_FIRST) && (r_next_free <= NF_LIMIT))
        else $error("next free code out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_START))
        else $error("accepted byte did not start processing");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL) |=> (!r_prefix_valid && (r_next_free == NF_FIRST)))
        else $error("stream end did not reset the prefix state");

endmodule

// ----- rtl/lzwc_dict.sv -----
// Hashed dictionary of (prefix, byte) pairs in one synchronous memory.
`timescale 1ns / 1ps
module lzwc_dict #(
    parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lzwc_pkg::t_dict_req             i_req,
    input  logic [CODE_BITS-1:0]            i_prefix,
    input  logic [lzwc_pkg::BYTE_BITS-1:0]  i_byte,
    input  logic [CODE_BITS-1:0]            i_code,
    output lzwc_pkg::t_dict_stat            o_stat,
    output logic [CODE_BITS-1:0]            o_code
);
    import lzwc_pkg::*;

    localparam int SLOT_BITS = CODE_BITS + 1;
    localparam int SLOTS     = 1 << SLOT_BITS;
    localparam int ENT_BITS  = EPOCH_BITS + 2 * CODE_BITS + BYTE_BITS;

    logic [ENT_BITS-1:0]   mem [SLOTS];
    logic [ENT_BITS-1:0]   r_rd_data;
    logic [SLOT_BITS-1:0]  r_addr, n_addr;
    logic [SLOT_BITS-1:0]  r_clr_addr;
    logic                  r_clearing;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [EPOCH_BITS-1:0] epoch_inc;
    logic [SLOT_BITS-1:0]  hash;
    logic                  rd_en;
    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [ENT_BITS-1:0]   wr_data;

    logic [EPOCH_BITS-1:0] ent_epoch;
    logic [CODE_BITS-1:0]  ent_prefix;
    logic [BYTE_BITS-1:0]  ent_byte;
    logic                  ent_live;

    always_comb begin
        hash = {i_prefix, 1'b0} ^ SLOT_BITS'(i_byte)
             ^ (SLOT_BITS'(i_byte) << (SLOT_BITS - BYTE_BITS));
    end

    always_comb begin
        rd_en  = i_req.lookup | i_req.probe_next;
        n_addr = r_addr;
        if (i_req.lookup) begin
            n_addr = hash;
        end else if (i_req.probe_next) begin
            n_addr = r_addr + SLOT_BITS'(1);
        end
    end

    // A slot counts as empty unless it was written during the current epoch.
    always_comb begin
        wr_en   = r_clearing | i_req.insert;
        wr_addr = r_clearing ? r_clr_addr : r_addr;
        wr_data = r_clearing ? '0 : {r_epoch, i_prefix, i_byte, i_code};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[n_addr];
        end
        r_addr <= n_addr;
    end

    assign epoch_inc = r_epoch + EPOCH_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_BITS'(1);
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + SLOT_BITS'(1);
                if (r_clr_addr == SLOT_BITS'(SLOTS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_req.new_epoch) begin
                if (epoch_inc == '0) begin
                    // Epoch marks have run out: wipe the table and start over.
                    r_epoch    <= EPOCH_BITS'(1);
                    r_clearing <= 1'b1;
                    r_clr_addr <= '0;
                end else begin
                    r_epoch <= epoch_inc;
                end
            end
        end
    end

    assign ent_epoch  = r_rd_data[ENT_BITS-1 -: EPOCH_BITS];
    assign ent_prefix = r_rd_data[CODE_BITS+BYTE_BITS +: CODE_BITS];
    assign ent_byte   = r_rd_data[CODE_BITS +: BYTE_BITS];
    assign ent_live   = (ent_epoch == r_epoch);

    assign o_code        = r_rd_data[CODE_BITS-1:0];
    assign o_stat.busy   = r_clearing;
    assign o_stat.vacant = !ent_live;
    assign o_stat.hit    = ent_live && (ent_prefix == i_prefix) && (ent_byte == i_byte);

endmodule

// ----- rtl/lzwc_ofifo.sv -----
// Four-entry result queue in front of the code output channel.
`timescale 1ns / 1ps
module lzwc_ofifo #(
    parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [CODE_BITS-1:0] i_code,
    input  logic                 i_final,
    output logic                 o_room2,
    lzwc_code_if.source          o_code_ch
);
    localparam int DEPTH = 4;
    localparam int PTR_BITS = 2;

    logic [CODE_BITS:0]  q_data [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic                pop;

    assign pop = o_code_ch.valid && o_code_ch.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            q_data[r_wr_ptr] <= {i_final, i_code};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= r_count + (PTR_BITS+1)'(i_push) - (PTR_BITS+1)'(pop);
        end
    end

    assign o_room2              = (r_count <= (PTR_BITS+1)'(DEPTH - 2));
    assign o_code_ch.valid      = (r_count != '0);
    assign o_code_ch.code_word  = q_data[r_rd_ptr][CODE_BITS-1:0];
    assign o_code_ch.final_code = q_data[r_rd_ptr][CODE_BITS];

endmodule
